### design/pee_pkg.sv
// Package: constants, status codes and types for the postfix evaluator.
package pee_pkg;
    localparam int STACK_DEPTH = 32;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    localparam logic [7:0] SYM_ADD = 8'h2B;
    localparam logic [7:0] SYM_SUB = 8'h2D;
    localparam logic [7:0] SYM_MUL = 8'h2A;
    localparam logic [7:0] SYM_DIV = 8'h2F;
    localparam logic [7:0] SYM_POW = 8'h5E;
    localparam logic [7:0] SYM_D0  = 8'h30;
    localparam logic [7:0] SYM_D9  = 8'h39;

    localparam logic [1:0] OP_DIV = 2'd0;
    localparam logic [1:0] OP_POW = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } t_alu_rsp;
endpackage

### design/pee_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/pee_alu.sv
// Multicycle unit: restoring divide, square-and-multiply power, multiply.
module pee_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pee_pkg::t_alu_req i_req,
    output pee_pkg::t_alu_rsp o_rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_op;
    logic [5:0]  r_cnt;
    logic [31:0] r_x, r_y, r_acc, r_rem;
    logic        r_neg;
    logic        r_ph;
    logic [32:0] w_trial;
    logic [31:0] w_prod;

    assign w_trial = {r_rem, r_x[31]} - {1'b0, r_y};
    assign w_prod  = r_ph ? (r_x * r_x) : (r_acc * r_x);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.start) n_state = (i_req.op == pee_pkg::OP_MUL) ? S_MUL : S_RUN;
            S_RUN:  if (r_cnt == 6'd0) n_state = S_DONE;
            S_MUL:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: begin
                r_op  <= i_req.op;
                r_rem <= '0;
                r_ph  <= 1'b0;
                if (i_req.op == pee_pkg::OP_DIV) begin
                    r_neg <= i_req.a[31] ^ i_req.b[31];
                    r_x   <= i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
                    r_y   <= i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;
                    r_cnt <= 6'd31;
                end else begin
                    r_x   <= (i_req.op == pee_pkg::OP_MUL) ? i_req.b : i_req.a;
                    r_y   <= i_req.b;
                    r_neg <= 1'b0;
                    r_cnt <= 6'd63;
                    r_acc <= (i_req.op == pee_pkg::OP_MUL) ? i_req.a : 32'd1;
                end
            end
            S_MUL: r_acc <= w_prod;
            S_RUN: begin
                if (r_op == pee_pkg::OP_DIV) begin
                    r_cnt <= r_cnt - 6'd1;
                    r_x   <= {r_x[30:0], ~w_trial[32]};
                    r_rem <= w_trial[32] ? {r_rem[30:0], r_x[31]} : w_trial[31:0];
                end else if (r_y[31]) begin
                    r_cnt <= 6'd0;
                    if (r_x == 32'd1) begin
                        r_acc <= 32'd1;
                    end else if (r_x == 32'hFFFF_FFFF) begin
                        r_acc <= r_y[0] ? 32'hFFFF_FFFF : 32'd1;
                    end else begin
                        r_acc <= 32'd0;
                    end
                end else if (!r_ph) begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_y[0]) r_acc <= w_prod;
                    r_y  <= r_y >> 1;
                    r_ph <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                    r_x   <= w_prod;
                    r_ph  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == S_DONE);
        if (r_op == pee_pkg::OP_DIV) begin
            o_rsp.value = r_neg ? (32'd0 - r_x) : r_x;
        end else begin
            o_rsp.value = r_acc;
        end
    end
endmodule

### design/postfix_expression_evaluator_unit.sv
// Postfix expression evaluator: operand stack in RAM, multicycle ALU.
// Digits, add, subtract and error beats bypass the ALU; multiply, divide and power use it,
// power with a negative exponent finishing early. One beat in flight.
// Result beat is valid the cycle after the last beat finishes and is held in an
// output register; next input is taken meanwhile, a second result waits for it.
// Synchronous active-low reset clears count, status and control; stack RAM is not cleared.
module postfix_expression_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] result_value, [34:32] status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD1   = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [7:0]  r_sym;
    logic        r_last;
    logic [pee_pkg::CW-1:0] r_cnt;
    logic [2:0]  r_st;
    logic [31:0] r_r, r_v;
    logic        r_ovalid;
    logic [31:0] r_oval;
    logic [2:0]  r_ost;
    logic [31:0] r_top;

    logic                   w_we;
    logic [pee_pkg::AW-1:0] w_waddr, w_raddr;
    logic [31:0]            w_wdata, w_rdata;
    pee_pkg::t_alu_req      w_req;
    pee_pkg::t_alu_rsp      w_rsp;
    logic                   w_digit, w_oper;
    logic                   w_addsub, w_out_go;

    pee_ram #(.WIDTH(32), .DEPTH(pee_pkg::STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    pee_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_digit = (r_sym >= pee_pkg::SYM_D0) && (r_sym <= pee_pkg::SYM_D9);
    assign w_oper  = (r_sym == pee_pkg::SYM_ADD) || (r_sym == pee_pkg::SYM_SUB) ||
                     (r_sym == pee_pkg::SYM_MUL) || (r_sym == pee_pkg::SYM_DIV) ||
                     (r_sym == pee_pkg::SYM_POW);
    assign w_addsub = (r_st == pee_pkg::ST_OK) && (r_cnt >= pee_pkg::CW'(2)) &&
                      (r_sym == pee_pkg::SYM_ADD || r_sym == pee_pkg::SYM_SUB);
    assign w_out_go = (r_state == S_OUT) && r_last && (!r_ovalid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        w_raddr = pee_pkg::AW'(r_cnt - pee_pkg::CW'(2));
        if (r_state == S_RD1) w_raddr = pee_pkg::AW'(r_cnt - pee_pkg::CW'(1));
        w_we    = 1'b0;
        w_waddr = pee_pkg::AW'(r_cnt - pee_pkg::CW'(2));
        w_wdata = r_v;
        if (r_state == S_EXEC && w_digit) begin
            w_we    = (r_st == pee_pkg::ST_OK) && (r_cnt < pee_pkg::CW'(pee_pkg::STACK_DEPTH));
            w_waddr = pee_pkg::AW'(r_cnt);
            w_wdata = {28'd0, 4'(r_sym - pee_pkg::SYM_D0)};
        end else if (r_state == S_WAIT && w_rsp.done) begin
            w_we    = 1'b1;
            w_wdata = w_rsp.value;
        end else if (r_state == S_FIN && r_sym != 8'd0) begin
            w_we = 1'b1;
        end
        w_req.start = (r_state == S_EXEC) && w_oper && (r_st == pee_pkg::ST_OK)
                      && (r_cnt >= pee_pkg::CW'(2))
                      && (r_sym == pee_pkg::SYM_MUL || r_sym == pee_pkg::SYM_POW ||
                          (r_sym == pee_pkg::SYM_DIV && r_r != 32'd0));
        w_req.op = (r_sym == pee_pkg::SYM_DIV) ? pee_pkg::OP_DIV :
                   (r_sym == pee_pkg::SYM_POW) ? pee_pkg::OP_POW : pee_pkg::OP_MUL;
        w_req.a = w_rdata;
        w_req.b = r_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_st     <= pee_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_sym   <= s_axis_tdata;
                    r_last  <= s_axis_tlast;
                    r_state <= S_RD1;
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: begin
                    r_r     <= w_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= w_req.start ? S_WAIT : S_FIN;
                    r_sym   <= {7'd0, w_addsub};
                    if (r_st == pee_pkg::ST_OK) begin
                        if (w_digit) begin
                            if (r_cnt < pee_pkg::CW'(pee_pkg::STACK_DEPTH)) begin
                                r_cnt <= r_cnt + pee_pkg::CW'(1);
                            end else begin
                                r_st <= pee_pkg::ST_OVER;
                            end
                        end else if (!w_oper) begin
                            r_st <= pee_pkg::ST_BAD;
                        end else if (r_cnt < pee_pkg::CW'(2)) begin
                            r_st <= pee_pkg::ST_UNDER;
                        end else if (r_sym == pee_pkg::SYM_DIV && r_r == 32'd0) begin
                            r_st <= pee_pkg::ST_DIVZ;
                        end else if (r_sym == pee_pkg::SYM_ADD) begin
                            r_v <= w_rdata + r_r;
                        end else if (r_sym == pee_pkg::SYM_SUB) begin
                            r_v <= w_rdata - r_r;
                        end
                    end
                end
                S_WAIT: if (w_rsp.done) begin
                    r_sym   <= 8'd0;
                    r_cnt   <= r_cnt - pee_pkg::CW'(1);
                    r_state <= S_OUT;
                end
                S_FIN: begin
                    if (r_sym != 8'd0) r_cnt <= r_cnt - pee_pkg::CW'(1);
                    r_sym   <= 8'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_out_go) begin
                r_cnt <= '0;
                r_st  <= pee_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_go) begin
            r_ost  <= (r_st == pee_pkg::ST_OK && r_cnt == '0) ? pee_pkg::ST_UNDER : r_st;
            r_oval <= (r_st == pee_pkg::ST_OK && r_cnt != '0) ? r_top : 32'd0;
        end
    end

    // Top-of-stack shadow: tracks the entry at count-1 on every write.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_top <= w_wdata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ost, r_oval};
endmodule

### tb/sv/postfix_expression_evaluator_unit_chk.sv
// Checker: watches both streams, predicts postfix results and compares them.
module postfix_expression_evaluator_unit_chk
    import pee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [31:0] result_value, [34:32] status
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } t_eval_result;

    logic [31:0]    opnd_stack [STACK_DEPTH];
    int             opnd_count;
    logic [2:0]     err_status;
    t_eval_result   expected_q [$];

    function automatic logic [31:0] wrap_pow(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 32'd1;
        sq  = base;
        if (expo[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (expo != 0) begin
            if (expo[0]) acc = acc * sq;
            sq   = sq * sq;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    task automatic eval_symbol(logic [7:0] sym);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] v;
        if (sym >= SYM_D0 && sym <= SYM_D9) begin
            if (opnd_count >= STACK_DEPTH) begin
                err_status = ST_OVER;
                return;
            end
            opnd_stack[opnd_count] = 32'(sym - SYM_D0);
            opnd_count++;
            return;
        end
        if (!(sym inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_POW})) begin
            err_status = ST_BAD;
            return;
        end
        if (opnd_count < 2) begin
            err_status = ST_UNDER;
            return;
        end
        rhs = opnd_stack[opnd_count-1];
        lhs = opnd_stack[opnd_count-2];
        case (sym)
            SYM_ADD: v = lhs + rhs;
            SYM_SUB: v = lhs - rhs;
            SYM_MUL: v = lhs * rhs;
            SYM_DIV: begin
                if (rhs == 0) begin
                    err_status = ST_DIVZ;
                    return;
                end
                v = trunc_div(lhs, rhs);
            end
            default: v = wrap_pow(lhs, rhs);
        endcase
        opnd_stack[opnd_count-2] = v;
        opnd_count--;
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_eval_result got;
        t_eval_result exp_r;
        int           errs;
        if (!i_rst_n) begin
            opnd_count    = 0;
            err_status    = ST_OK;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            errs = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                if (err_status == ST_OK) eval_symbol(s_axis_tdata);
                if (s_axis_tlast) begin
                    exp_r.status = err_status;
                    if (exp_r.status == ST_OK && opnd_count == 0) exp_r.status = ST_UNDER;
                    exp_r.value = (exp_r.status == ST_OK) ? opnd_stack[opnd_count-1] : 32'd0;
                    expected_q.push_back(exp_r);
                    opnd_count = 0;
                    err_status = ST_OK;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[31:0];
                got.status = m_axis_tdata[34:32];
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat: value %0d status %0d",
                           $signed(got.value), got.status);
                    errs++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.value !== exp_r.value) begin
                        $error("result_value: expected %0d actual %0d",
                               $signed(exp_r.value), $signed(got.value));
                        errs++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, got.status);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

### tb/sv/postfix_expression_evaluator_unit_tb.sv
// Testbench top: clock, reset, postfix symbol stimulus, stalls and verdict.
module postfix_expression_evaluator_unit_tb;
    import pee_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    localparam logic [7:0] SYM_D1 = SYM_D0 + 8'd1;
    localparam logic [7:0] SYM_D2 = SYM_D0 + 8'd2;
    localparam logic [7:0] SYM_D3 = SYM_D0 + 8'd3;
    localparam logic [7:0] SYM_D4 = SYM_D0 + 8'd4;
    localparam logic [7:0] SYM_D5 = SYM_D0 + 8'd5;
    localparam logic [7:0] SYM_D6 = SYM_D0 + 8'd6;
    localparam logic [7:0] SYM_D7 = SYM_D0 + 8'd7;
    localparam logic [7:0] SYM_D8 = SYM_D0 + 8'd8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] symbol
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] result_value, [34:32] status
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    typedef struct {
        logic [7:0] sym;
        logic       last;
    } t_symbol_beat;

    t_symbol_beat sym_q [$];

    always #6 i_clk = ~i_clk;

    postfix_expression_evaluator_unit u_top (.*);

    postfix_expression_evaluator_unit_chk u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 4))
            0: return SYM_ADD;
            1: return SYM_SUB;
            2: return SYM_MUL;
            3: return SYM_DIV;
            default: return SYM_POW;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return SYM_D0 + 8'($urandom_range(0, 9));
    endfunction

    task automatic put(logic [7:0] sym, logic last = 1'b0);
        t_symbol_beat b;
        b.sym  = sym;
        b.last = last;
        sym_q.push_back(b);
    endtask

    // Random expression, operators placed only on two or more tracked operands; occasionally noisy.
    task automatic put_random_expr();
        int depth;
        int n;
        int maxd;
        depth = 0;
        maxd  = ($urandom_range(0, 15) == 0) ? STACK_DEPTH + 2 : $urandom_range(1, 6);
        n     = $urandom_range(1, 14);
        repeat (n) begin
            if ($urandom_range(0, 40) == 0) put(8'($urandom()));
            else if (depth >= 2 && (depth >= maxd || $urandom_range(0, 1))) begin
                put(pick_op());
                depth--;
            end else begin
                put(pick_digit());
                depth++;
            end
        end
        if ($urandom_range(0, 3) == 0) put(8'($urandom()), 1'b1);
        else if (depth >= 2) put(pick_op(), 1'b1);
        else put(pick_digit(), 1'b1);
    endtask

    initial begin
        // Directed: wrap, min by -1, pow edge cases, errors.
        put(SYM_D9); put(SYM_D0, 1'b1);
        put(SYM_D0); put(SYM_D9); put(SYM_SUB, 1'b1);                 // -9
        put(SYM_D0); put(SYM_D1); put(SYM_SUB); put(SYM_D0);
        put(SYM_D1); put(SYM_SUB); put(SYM_POW, 1'b1);                // (-1)^-1
        put(SYM_D0); put(SYM_D1); put(SYM_SUB); put(SYM_D0);
        put(SYM_D2); put(SYM_SUB); put(SYM_POW, 1'b1);                // (-1)^-2
        put(SYM_D1); put(SYM_D0); put(SYM_D3); put(SYM_SUB); put(SYM_POW, 1'b1);
        put(SYM_D2); put(SYM_D0); put(SYM_D3); put(SYM_SUB); put(SYM_POW, 1'b1);
        put(SYM_D0); put(SYM_D0); put(SYM_POW, 1'b1);                 // 0^0
        put(SYM_D2); put(SYM_D9); put(SYM_D9); put(SYM_MUL); put(SYM_POW, 1'b1);
        put(SYM_D0); put(SYM_D2); put(SYM_SUB); put(SYM_D3); put(SYM_D9);
        put(SYM_MUL); put(SYM_D4); put(SYM_ADD); put(SYM_POW);        // (-2)^31
        put(SYM_D0); put(SYM_D1); put(SYM_SUB); put(SYM_DIV, 1'b1);   // min / -1
        put(SYM_D7); put(SYM_D0); put(SYM_DIV, 1'b1);                 // divide by zero
        put(SYM_D0); put(SYM_D7); put(SYM_SUB); put(SYM_D2); put(SYM_DIV, 1'b1);
        put(SYM_D3); put(SYM_ADD, 1'b1);                              // underflow
        put(SYM_D1, 1'b0); put(8'hFF); put(SYM_D2, 1'b1);             // bad symbol
        put(8'h00, 1'b1);
        put(SYM_ADD, 1'b1);
        repeat (STACK_DEPTH + 1) put(SYM_D9);                         // overflow
        put(SYM_ADD, 1'b1);
        repeat (STACK_DEPTH) put(SYM_D5);                             // full, ok
        put(SYM_ADD, 1'b0);
        put(SYM_D3, 1'b1);
        put(SYM_D4); put(SYM_D6); put(SYM_D8, 1'b1);                  // leftovers
        while (sym_q.size() < 1800) put_random_expr();
        // Bit coverage of the symbol field.
        put(8'h80, 1'b1); put(8'h7F, 1'b1);
    end

    // Sender: bursts and gaps.
    initial begin
        int burst;
        int gap;
        t_symbol_beat b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (sym_q.size() > 0) begin
            burst = $urandom_range(1, 20);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            while (burst > 0 && sym_q.size() > 0) begin
                b = sym_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= b.sym;
                s_axis_tlast  <= b.last;
                @(posedge i_clk);
                while (!s_axis_tready) @(posedge i_clk);
                burst--;
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: stall pattern, with one long hold-off.
    initial begin
        int cnt;
        cnt = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            cnt++;
            if (cnt == 3000) begin
                hold_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            case (cnt / 500 % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= (cnt % 7 < 2);
                default: m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Watchdog and verdict.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (stim_done && pending == 0) begin
                repeat (200) @(posedge i_clk);
                if (fail_count == 0 && pending == 0 && !m_axis_tvalid) begin
                    $display("== PASS ==");
                end else begin
                    $display("== FAIL ==");
                end
                $finish;
            end
        end
    end
endmodule
